FILE: rtl/core/bcu_pkg.sv
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared types and constants of the 2x bicubic upscaler.
// ----------------------------------------------------------------------------
package bcu_pkg;

	// depth of the column queue between front and back
	localparam int FQ_DEPTH = 4;
	localparam int FQ_PTR_BITS = 2;
	localparam int FQ_CNT_BITS = 3;

	localparam int IMG_WIDTH_BITS = 11;
	localparam logic [IMG_WIDTH_BITS-1:0] IMG_WIDTH_RESET = 11'd256;

	localparam int POS_BITS = 11;
	localparam int FRAC_BITS = 28;

	// Catmull-Rom taps, Q14; row 0 is t=1/3, row 1 is t=1/2
	localparam logic signed [15:0] WTAB [2][4] = '{
		'{-16'sd1214, 16'sd12743, 16'sd5461, -16'sd607},
		'{-16'sd1024, 16'sd9216, 16'sd9216, -16'sd1024}
	};

	typedef struct packed {
		logic emit_main; // window at this column is complete
		logic flush;     // last column of an output row: three zero columns follow
	} bcu_ctl_t;

endpackage

FILE: rtl/core/bcu_fifo.sv
// ----------------------------------------------------------------------------
// bcu_fifo
// Short queue of column items between the front and the back.
// ----------------------------------------------------------------------------
module bcu_fifo import bcu_pkg::*; #(
	parameter int DW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [DW-1:0]          push_data,
	input  logic                   pop,
	output logic [DW-1:0]          pop_data,
	output logic [FQ_CNT_BITS-1:0] count
);

	logic [DW-1:0]          mem_q [FQ_DEPTH];
	logic [FQ_PTR_BITS-1:0] wr_ptr_q;
	logic [FQ_PTR_BITS-1:0] rd_ptr_q;
	logic [FQ_CNT_BITS-1:0] cnt_q;

	assign pop_data = mem_q[rd_ptr_q];
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != FQ_CNT_BITS'(FQ_DEPTH) || pop))
		else $error("column queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("column queue underflow");

endmodule

FILE: rtl/core/bcu_front.sv
// ----------------------------------------------------------------------------
// bcu_front
// Takes source items, tracks frame position, keeps three line buffers and
// hands one four-sample column per item to the queue.
// ----------------------------------------------------------------------------
module bcu_front import bcu_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int SAMPLE_BITS = 16,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_WIDTH + 3)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          action,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          cfg_write,
	input  logic [IMG_WIDTH_BITS-1:0]     cfg_width,
	output logic                          col_valid,
	output logic signed [SAMPLE_BITS-1:0] col0,
	output logic signed [SAMPLE_BITS-1:0] col1,
	output logic signed [SAMPLE_BITS-1:0] col2,
	output logic signed [SAMPLE_BITS-1:0] col3,
	output logic [CW-1:0]                 col_x,
	output logic [RW-1:0]                 col_y,
	output bcu_ctl_t                      col_ctl
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

	logic [IMG_WIDTH_BITS-1:0] width_q;
	logic [CW-1:0]             col_q;
	logic [RW-1:0]             row_q;
	logic [1:0]                bank_q;

	logic [WW-1:0]             eff_w;
	logic                      last_col;
	logic                      row3;
	logic signed [SAMPLE_BITS-1:0] pix;

	logic signed [SAMPLE_BITS-1:0] mem0_q [MAX_WIDTH];
	logic signed [SAMPLE_BITS-1:0] mem1_q [MAX_WIDTH];
	logic signed [SAMPLE_BITS-1:0] mem2_q [MAX_WIDTH];
	logic signed [SAMPLE_BITS-1:0] rd0_q, rd1_q, rd2_q;

	logic                          vld_s1;
	logic signed [SAMPLE_BITS-1:0] pix_s1;
	logic [CW-1:0]                 x_s1;
	logic [RW-1:0]                 y_s1;
	bcu_ctl_t                      ctl_s1;
	logic [1:0]                    bank_s1;

	always_comb begin
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = MAXW;
		end else begin
			eff_w = WW'(width_q);
		end
	end

	assign last_col = (col_q == CW'(eff_w - 1'b1));
	assign row3 = (row_q >= RW'(3));
	// pad rows and pad items read as zero
	assign pix = (row_q < RW'(eff_w) && !action) ? sample : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= IMG_WIDTH_RESET;
			col_q <= '0;
			row_q <= '0;
			bank_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (cfg_write) begin
				width_q <= cfg_width;
				col_q <= '0;
				row_q <= '0;
				bank_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					if (row_q == RW'(eff_w) + RW'(2)) begin
						row_q <= '0;
						bank_q <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						bank_q <= (bank_q == 2'd2) ? 2'd0 : bank_q + 2'd1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
			x_s1 <= col_q;
			y_s1 <= row_q - RW'(3);
			ctl_s1.emit_main <= row3 && (col_q >= CW'(3));
			ctl_s1.flush <= row3 && last_col;
			bank_s1 <= bank_q;
		end
	end

	// line buffers, read before write
	always_ff @(posedge clk) begin
		if (accept) begin
			rd0_q <= mem0_q[col_q];
			if (bank_q == 2'd0) begin
				mem0_q[col_q] <= pix;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd1_q <= mem1_q[col_q];
			if (bank_q == 2'd1) begin
				mem1_q[col_q] <= pix;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd2_q <= mem2_q[col_q];
			if (bank_q == 2'd2) begin
				mem2_q[col_q] <= pix;
			end
		end
	end

	// oldest row first
	always_comb begin
		unique case (bank_s1)
			2'd1: begin
				col0 = rd1_q;
				col1 = rd2_q;
				col2 = rd0_q;
			end
			2'd2: begin
				col0 = rd2_q;
				col1 = rd0_q;
				col2 = rd1_q;
			end
			default: begin
				col0 = rd0_q;
				col1 = rd1_q;
				col2 = rd2_q;
			end
		endcase
	end

	assign col3 = pix_s1;
	assign col_valid = vld_s1;
	assign col_x = x_s1;
	assign col_y = y_s1;
	assign col_ctl = ctl_s1;

	a_bank_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		bank_q != 2'd3)
		else $error("line buffer bank out of range");

endmodule

FILE: rtl/core/bcu_back.sv
// ----------------------------------------------------------------------------
// bcu_back
// Holds the 4x4 window and computes the four interpolated pixels of each
// window with one vertical/horizontal multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module bcu_back import bcu_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int SAMPLE_BITS = 16,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_WIDTH + 3)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          col_avail,
	output logic                          col_pop,
	input  logic signed [SAMPLE_BITS-1:0] col0,
	input  logic signed [SAMPLE_BITS-1:0] col1,
	input  logic signed [SAMPLE_BITS-1:0] col2,
	input  logic signed [SAMPLE_BITS-1:0] col3,
	input  logic [CW-1:0]                 col_x,
	input  logic [RW-1:0]                 col_y,
	input  bcu_ctl_t                      col_ctl,
	input  logic                          res_pop,
	output logic                          res_valid,
	output logic signed [SAMPLE_BITS-1:0] res_value,
	output logic [POS_BITS-1:0]           res_x,
	output logic [POS_BITS-1:0]           res_y,
	output logic                          res_last
);

	localparam int SB = SAMPLE_BITS;
	localparam int VW = SB + 15;
	localparam int AW = SB + 31;
	localparam int QW = AW + 1 - FRAC_BITS;
	localparam logic signed [QW-1:0] QHI = QW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [QW-1:0] QLO = -QHI - QW'(1);

	typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_MAC, S_OUT} state_t;

	state_t state_q;
	logic signed [SB-1:0] win_q [4][4];
	logic [CW-1:0] x_q;
	logic [RW-1:0] y_q;
	bcu_ctl_t ctl_q;
	logic [1:0] k_q;
	logic [1:0] sub_q;
	logic [2:0] mj_q;

	logic issue;
	logic signed [VW-1:0] vsum;
	logic signed [VW-1:0] vsum_s1;
	logic [1:0] j_s1;
	logic vld_s1, end_s1;
	logic signed [AW-1:0] prod_s2;
	logic vld_s2, end_s2, first_s2;
	logic signed [AW-1:0] acc_q;
	logic done_q;

	logic signed [AW:0] rnd;
	logic signed [QW-1:0] q;
	logic signed [SB-1:0] sat;
	logic [1:0] k_nx;
	logic [CW+1:0] xw;
	logic [CW+2:0] ox;
	logic [RW:0] oy;
	logic out_vld_q;

	assign issue = (state_q == S_MAC) && !mj_q[2];
	assign col_pop = (state_q == S_IDLE) && col_avail;
	assign k_nx = k_q + 2'd1;

	// vertical taps of one window column
	always_comb begin
		logic signed [SB+15:0] p;
		vsum = '0;
		for (int i = 0; i < 4; i++) begin
			p = WTAB[sub_q[1]][i] * win_q[i][mj_q[1:0]];
			vsum = vsum + VW'(p);
		end
	end

	always_comb begin
		rnd = (AW+1)'(acc_q) + (AW+1)'(64'sd1 <<< (FRAC_BITS - 1));
		q = QW'(rnd >>> FRAC_BITS);
		if (q > QHI) begin
			sat = SB'(QHI);
		end else if (q < QLO) begin
			sat = SB'(QLO);
		end else begin
			sat = SB'(q);
		end
		xw = (CW+2)'(x_q) + (CW+2)'(k_q) - (CW+2)'(3);
		ox = {xw, sub_q[0]};
		oy = {y_q, sub_q[1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			done_q <= vld_s2 && end_s2;
		end
	end

	always_ff @(posedge clk) begin
		vsum_s1 <= vsum;
		j_s1 <= mj_q[1:0];
		end_s1 <= (mj_q[1:0] == 2'd3);
		prod_s2 <= vsum_s1 * WTAB[sub_q[0]][j_s1];
		end_s2 <= end_s1;
		first_s2 <= (j_s1 == 2'd0);
		if (vld_s2) begin
			acc_q <= (first_s2 ? '0 : acc_q) + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			sub_q <= '0;
			mj_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			// in S_OUT a pop always reloads the output register below
			if (res_pop && state_q != S_OUT) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (col_avail) begin
						k_q <= '0;
						sub_q <= '0;
						mj_q <= '0;
						if (col_ctl.emit_main) begin
							state_q <= S_MAC;
						end else if (col_ctl.flush) begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					k_q <= k_nx;
					if ((CW+2)'(x_q) + (CW+2)'(k_nx) >= (CW+2)'(3)) begin
						sub_q <= '0;
						mj_q <= '0;
						state_q <= S_MAC;
					end
				end
				S_MAC: begin
					if (!mj_q[2]) begin
						mj_q <= mj_q + 3'd1;
					end
					if (done_q) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_vld_q || res_pop) begin
						out_vld_q <= 1'b1;
						if (sub_q != 2'd3) begin
							sub_q <= sub_q + 2'd1;
							mj_q <= '0;
							state_q <= S_MAC;
						end else if (ctl_q.flush && k_q != 2'd3) begin
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// window and result payload
	always_ff @(posedge clk) begin
		if (col_pop) begin
			x_q <= col_x;
			y_q <= col_y;
			ctl_q <= col_ctl;
		end
		if (col_pop || state_q == S_SHIFT) begin
			for (int i = 0; i < 4; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
				win_q[i][2] <= win_q[i][3];
			end
			win_q[0][3] <= col_pop ? col0 : '0;
			win_q[1][3] <= col_pop ? col1 : '0;
			win_q[2][3] <= col_pop ? col2 : '0;
			win_q[3][3] <= col_pop ? col3 : '0;
		end
		if (state_q == S_OUT && (!out_vld_q || res_pop)) begin
			res_value <= sat;
			res_x <= POS_BITS'(ox);
			res_y <= POS_BITS'(oy);
			res_last <= (sub_q == 2'd3) && (k_q == 2'd3 || !ctl_q.flush);
		end
	end

	assign res_valid = out_vld_q;

	a_done_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_MAC)
		else $error("accumulate finished outside MAC state");

	a_pipe_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> state_q == S_MAC)
		else $error("product stage active outside MAC state");

	a_shift_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> k_q != 2'd3)
		else $error("zero shift past the row end");

endmodule

FILE: rtl/core/bicubic_upscale_2x.sv
// ----------------------------------------------------------------------------
// bicubic_upscale_2x
// Two-times Catmull-Rom upscaler of a square image.
// ----------------------------------------------------------------------------
// Feed the W*W source pixels in raster order, then 3*W pad items (zero rows);
// each complete 4x4 window yields four results (dy outer, dx inner), and the
// last column of each output row adds up to three more windows with zeros
// beyond the right edge, so one item gives 0, 4, 8, 12 or 16 results, the
// final one flagged by last. Each result passes through the single shared
// multiply-accumulate datapath of the back end (four column steps, three
// pipeline stages, then the output load), and the back end pops the next
// column from the queue only once it is idle again; the front end and a
// 4-deep column queue let input keep flowing while results wait. Writing
// image_width restarts the frame; write it only while the block is idle.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
module bicubic_upscale_2x import bcu_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          action,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS-1:0] out_value,
	output logic [POS_BITS-1:0]           out_x,
	output logic [POS_BITS-1:0]           out_y,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [IMG_WIDTH_BITS-1:0]     image_width
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_WIDTH + 3);
	localparam int SB = SAMPLE_BITS;
	localparam int DW = 4 * SB + CW + RW + $bits(bcu_ctl_t);

	logic accept;
	logic col_valid;
	logic signed [SB-1:0] f0, f1, f2, f3, b0, b1, b2, b3;
	logic [CW-1:0] fx, bx;
	logic [RW-1:0] fy, by;
	bcu_ctl_t fctl, bctl;
	logic [DW-1:0] qin, qout;
	logic [FQ_CNT_BITS-1:0] qcnt;
	logic qpop;
	logic res_valid;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;
	// leave room for the item still in the line buffer read stage
	assign full = (qcnt == FQ_CNT_BITS'(FQ_DEPTH))
		|| (col_valid && qcnt == FQ_CNT_BITS'(FQ_DEPTH - 1));

	bcu_front #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.action(action),
		.sample(sample),
		.cfg_write(cfg_valid && cfg_ready),
		.cfg_width(image_width),
		.col_valid(col_valid),
		.col0(f0),
		.col1(f1),
		.col2(f2),
		.col3(f3),
		.col_x(fx),
		.col_y(fy),
		.col_ctl(fctl)
	);

	assign qin = {f3, f2, f1, f0, fx, fy, fctl};
	assign {b3, b2, b1, b0, bx, by, bctl} = qout;

	bcu_fifo #(.DW(DW)) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(col_valid),
		.push_data(qin),
		.pop(qpop),
		.pop_data(qout),
		.count(qcnt)
	);

	bcu_back #(.MAX_WIDTH(MAX_WIDTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.col_avail(qcnt != '0),
		.col_pop(qpop),
		.col0(b0),
		.col1(b1),
		.col2(b2),
		.col3(b3),
		.col_x(bx),
		.col_y(by),
		.col_ctl(bctl),
		.res_pop(pop && !empty),
		.res_valid(res_valid),
		.res_value(out_value),
		.res_x(out_x),
		.res_y(out_y),
		.res_last(last)
	);

	assign empty = !res_valid;

endmodule
